### src/prpd_pkg.sv
package prpd_pkg;

    // Row geometry: PLANES bit planes of PLANE_BYTES bytes each.
    localparam int PLANES      = 4;
    localparam int ROW_BYTES   = 160;
    localparam int PLANE_BYTES = ROW_BYTES / PLANES;

    // Only four color bits reach a pixel.
    localparam int COLOR_PLANES = (PLANES < 4) ? PLANES : 4;

    localparam int LANE_W  = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int GROUP_W = 6;

    localparam logic [7:0] LIMIT_RESET = 8'd200;
    localparam logic [7:0] SKIP_HEADER = 8'h80;

    // One column of the row store: the byte of every plane at one offset.
    typedef logic [PLANES-1:0][7:0] plane_word_t;

    // Planar to chunky: pixel i takes bit 7-i of each plane, plane b gives color bit b.
    function automatic logic [31:0] to_chunky(input plane_word_t planes);
        logic [31:0] word;
        word = '0;
        for (int i = 0; i < 8; i++)
        begin
            for (int b = 0; b < COLOR_PLANES; b++)
            begin
                word[4*i + b] = planes[b][7-i];
            end
        end
        return word;
    endfunction

endpackage

### src/packbits_planar_row_decoder.sv
// Header bytes are taken in the idle state; a literal byte or a repeat is written in the run
// state through the one-byte-per-cycle write port of the row store, which pauses for row output.
// A completed row is output one pixel group at a time through EMIT_RD and EMIT_WR, waiting while
// the output stalls; the first group follows the write that fills the row through both states.
// Reset (rst_n, asynchronous, active low) clears decoder state and sets the row limit to 200;
// the row store is not cleared, since every byte is written before it is read.
module packbits_planar_row_decoder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   body_byte,
    input  logic                         chunk_end,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [7:0]                   rows_limit,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   row_index,
    output logic [prpd_pkg::GROUP_W-1:0] group_index,
    output logic [31:0]                  pixel_group,
    output logic                         row_last
);
    import prpd_pkg::*;

    typedef enum logic [1:0] {
        MODE_HEADER,
        MODE_REPEAT,
        MODE_LITERAL
    } decode_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

    localparam logic [LANE_W-1:0]  LAST_LANE = LANE_W'(PLANES - 1);
    localparam logic [GROUP_W-1:0] LAST_COL  = GROUP_W'(PLANE_BYTES - 1);

    state_t              state_reg, state_next;
    decode_mode_t        mode_reg, mode_next;
    logic [7:0]          left_reg, left_next;
    logic [7:0]          cnt_reg, cnt_next;
    logic [7:0]          rows_reg, rows_next;
    logic [7:0]          limit_reg, limit_next;
    logic [LANE_W-1:0]   lane_reg, lane_next;
    logic [GROUP_W-1:0]  col_reg, col_next;
    logic [GROUP_W-1:0]  group_reg, group_next;
    logic [7:0]          byte_reg, byte_next;
    logic                end_reg, end_next;
    logic                lit_reg, lit_next;
    logic                stop_reg, stop_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_row_reg, out_row_next;
    logic [GROUP_W-1:0]  out_group_reg, out_group_next;
    logic [31:0]         out_pixel_reg, out_pixel_next;
    logic                out_last_reg, out_last_next;

    // Row store: one column per pixel group, one byte lane per plane.
    plane_word_t         row_mem [PLANE_BYTES];
    plane_word_t         rdata_reg;
    logic                mem_we;
    logic                mem_re;
    logic [7:0]          left_fin;
    logic [7:0]          rows_inc;

    assign in_ready    = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign row_index   = out_row_reg;
    assign group_index = out_group_reg;
    assign pixel_group = out_pixel_reg;
    assign row_last    = out_last_reg;

    assign rows_inc = rows_reg + 8'd1;

    // Store port: byte-lane write during a run, column read during row output.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[col_reg][lane_reg] <= byte_reg;
        end
        if (mem_re)
        begin
            rdata_reg <= row_mem[group_reg];
        end
    end

    // Next-state logic for decoding, store writes and row output.
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        left_next      = left_reg;
        cnt_next       = cnt_reg;
        rows_next      = rows_reg;
        limit_next     = limit_reg;
        lane_next      = lane_reg;
        col_next       = col_reg;
        group_next     = group_reg;
        byte_next      = byte_reg;
        end_next       = end_reg;
        lit_next       = lit_reg;
        stop_next      = stop_reg;
        out_valid_next = out_valid_reg;
        out_row_next   = out_row_reg;
        out_group_next = out_group_reg;
        out_pixel_next = out_pixel_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        left_fin       = 8'd0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            limit_next = rows_limit;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = body_byte;
                    end_next  = chunk_end;
                    stop_next = 1'b0;
                    if (rows_reg < limit_reg)
                    begin
                        unique case (mode_reg)
                            MODE_HEADER:
                            begin
                                if (body_byte == SKIP_HEADER)
                                begin
                                    mode_next = MODE_HEADER;
                                end
                                else if (body_byte[7])
                                begin
                                    left_next = 8'(9'd257 - {1'b0, body_byte});
                                    mode_next = MODE_REPEAT;
                                end
                                else
                                begin
                                    left_next = body_byte + 8'd1;
                                    mode_next = MODE_LITERAL;
                                end
                            end
                            MODE_REPEAT:
                            begin
                                cnt_next   = left_reg;
                                lit_next   = 1'b0;
                                state_next = ST_RUN;
                            end
                            MODE_LITERAL:
                            begin
                                cnt_next   = 8'd1;
                                lit_next   = 1'b1;
                                state_next = ST_RUN;
                            end
                            default:
                            begin
                                mode_next = MODE_HEADER;
                            end
                        endcase
                    end

                    // Data items finish in the run state; all others end here.
                    if (chunk_end && (state_next == ST_IDLE))
                    begin
                        mode_next = MODE_HEADER;
                        left_next = 8'd0;
                        lane_next = '0;
                        col_next  = '0;
                        rows_next = 8'd0;
                    end
                end
            end

            ST_RUN:
            begin
                if ((cnt_reg == 8'd0) || stop_reg)
                begin
                    // Item done: settle the decoder state.
                    if (lit_reg && !stop_reg)
                    begin
                        left_fin = left_reg - 8'd1;
                    end
                    left_next  = left_fin;
                    mode_next  = (left_fin == 8'd0) ? MODE_HEADER : MODE_LITERAL;
                    state_next = ST_IDLE;
                    if (end_reg)
                    begin
                        mode_next = MODE_HEADER;
                        left_next = 8'd0;
                        lane_next = '0;
                        col_next  = '0;
                        rows_next = 8'd0;
                    end
                end
                else
                begin
                    // Write one decoded byte and advance the fill position.
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg - 8'd1;
                    if ((lane_reg == LAST_LANE) && (col_reg == LAST_COL))
                    begin
                        lane_next  = '0;
                        col_next   = '0;
                        group_next = '0;
                        state_next = ST_EMIT_RD;
                    end
                    else if (col_reg == LAST_COL)
                    begin
                        col_next  = '0;
                        lane_next = lane_reg + LANE_W'(1);
                    end
                    else
                    begin
                        col_next = col_reg + GROUP_W'(1);
                    end
                end
            end

            ST_EMIT_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_EMIT_WR;
            end

            ST_EMIT_WR:
            begin
                // Load one pixel group once the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = rows_reg;
                    out_group_next = group_reg;
                    out_pixel_next = to_chunky(rdata_reg);
                    out_last_next  = (group_reg == LAST_COL);
                    if (group_reg == LAST_COL)
                    begin
                        rows_next  = rows_inc;
                        stop_next  = (rows_inc >= limit_reg);
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        group_next = group_reg + GROUP_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_HEADER;
            left_reg      <= 8'd0;
            cnt_reg       <= 8'd0;
            rows_reg      <= 8'd0;
            limit_reg     <= LIMIT_RESET;
            lane_reg      <= '0;
            col_reg       <= '0;
            group_reg     <= '0;
            end_reg       <= 1'b0;
            lit_reg       <= 1'b0;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            left_reg      <= left_next;
            cnt_reg       <= cnt_next;
            rows_reg      <= rows_next;
            limit_reg     <= limit_next;
            lane_reg      <= lane_next;
            col_reg       <= col_next;
            group_reg     <= group_next;
            end_reg       <= end_next;
            lit_reg       <= lit_next;
            stop_reg      <= stop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        out_row_reg   <= out_row_next;
        out_group_reg <= out_group_next;
        out_pixel_reg <= out_pixel_next;
        out_last_reg  <= out_last_next;
    end

endmodule
